// ===== rtl/core/flbm_pkg.sv =====
// Package for the fixed-latency block memory.
// Holds the geometry constants, field widths and transaction mode codes.
// No dependencies.
package flbm_pkg;

    localparam int NUM_BLOCKS      = 1024;
    localparam int WORDS_PER_BLOCK = 8;
    localparam int WORD_W          = 32;
    localparam int BLOCK_BYTES     = 32;
    localparam int ADDR_W          = 15;
    localparam int ID_W            = 8;
    localparam int LAT_W           = 8;
    localparam int ROW_W           = WORDS_PER_BLOCK * WORD_W;
    localparam int BLK_SHIFT       = $clog2(BLOCK_BYTES);
    localparam int MEM_AW          = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam logic [LAT_W-1:0] LAT_RESET     = LAT_W'(4);
    localparam logic [LAT_W-1:0] ELAPSED_RESET = LAT_W'(1);
    localparam logic [LAT_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [ID_W-1:0]  NO_OWNER      = '0;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

endpackage

// ===== rtl/core/flbm_if.sv =====
// Valid/ready channel interfaces for the fixed-latency block memory.
// Depends on flbm_pkg for field widths.
interface flbm_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic [flbm_pkg::ADDR_W-1:0]         address;
    logic [flbm_pkg::ID_W-1:0]           requester_id;
    logic [flbm_pkg::WORD_W-1:0]         write_word_0;
    logic [flbm_pkg::WORD_W-1:0]         write_word_1;
    logic [flbm_pkg::WORD_W-1:0]         write_word_2;
    logic [flbm_pkg::WORD_W-1:0]         write_word_3;
    logic [flbm_pkg::WORD_W-1:0]         write_word_4;
    logic [flbm_pkg::WORD_W-1:0]         write_word_5;
    logic [flbm_pkg::WORD_W-1:0]         write_word_6;
    logic [flbm_pkg::WORD_W-1:0]         write_word_7;

    modport source (
        output valid, mode, address, requester_id,
               write_word_0, write_word_1, write_word_2, write_word_3,
               write_word_4, write_word_5, write_word_6, write_word_7,
        input  ready
    );
    modport sink (
        input  valid, mode, address, requester_id,
               write_word_0, write_word_1, write_word_2, write_word_3,
               write_word_4, write_word_5, write_word_6, write_word_7,
        output ready
    );
endinterface

interface flbm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                done_res;
    logic [flbm_pkg::WORD_W-1:0]         read_word_0;
    logic [flbm_pkg::WORD_W-1:0]         read_word_1;
    logic [flbm_pkg::WORD_W-1:0]         read_word_2;
    logic [flbm_pkg::WORD_W-1:0]         read_word_3;
    logic [flbm_pkg::WORD_W-1:0]         read_word_4;
    logic [flbm_pkg::WORD_W-1:0]         read_word_5;
    logic [flbm_pkg::WORD_W-1:0]         read_word_6;
    logic [flbm_pkg::WORD_W-1:0]         read_word_7;

    modport source (
        output valid, done_res,
               read_word_0, read_word_1, read_word_2, read_word_3,
               read_word_4, read_word_5, read_word_6, read_word_7,
        input  ready
    );
    modport sink (
        input  valid, done_res,
               read_word_0, read_word_1, read_word_2, read_word_3,
               read_word_4, read_word_5, read_word_6, read_word_7,
        output ready
    );
endinterface

// ===== rtl/core/fixed_latency_block_memory.sv =====
// Fixed-latency block memory: top level.
// Depends on flbm_pkg and the channel interfaces in flbm_if.sv.
//
// Accepts one transaction per clock cycle while the input is not refused. Each
// transaction yields one result, which passes the pending stage to the output
// register: the synchronous block RAM is read at the accepting edge (a whole
// 256-bit row per access) and the row moves to the output register when the
// pending stage advances. A full output register stalls the pipeline; the input
// is refused only while the pending stage is held behind a full output register
// that is not being read. Ownership and the elapsed-cycle counter are decided at
// acceptance, so back-to-back transactions see each other's effects without
// interlock. Reads of a block never written since reset return undefined data.
module fixed_latency_block_memory (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [flbm_pkg::LAT_W-1:0]    i_cfg_data,
    flbm_in_if.sink                       i_in,
    flbm_out_if.source                    o_out
);

    logic [flbm_pkg::ROW_W-1:0]  mem [flbm_pkg::NUM_BLOCKS];
    logic [flbm_pkg::ROW_W-1:0]  r_rdata;

    logic [flbm_pkg::LAT_W-1:0]  r_latency;
    logic [flbm_pkg::LAT_W-1:0]  r_elapsed, n_elapsed;
    logic [flbm_pkg::ID_W-1:0]   r_owner, n_owner;

    logic                        r_pend, r_pend_done, r_pend_rd;
    logic                        r_out_vld, r_out_done;
    logic [flbm_pkg::ROW_W-1:0]  r_out_row;

    logic                        accept, advance;
    logic                        is_rw, owner_free, owner_ok, serve;
    logic [31:0]                 blk;
    logic                        in_store;
    logic [flbm_pkg::MEM_AW-1:0] mem_idx;
    logic [flbm_pkg::ROW_W-1:0]  wrow;

    assign advance    = r_pend && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_pend || advance;
    assign accept     = i_in.valid && i_in.ready;

    assign blk      = 32'(i_in.address >> flbm_pkg::BLK_SHIFT);
    assign in_store = blk < 32'(flbm_pkg::NUM_BLOCKS);
    assign mem_idx  = blk[flbm_pkg::MEM_AW-1:0];
    assign wrow     = {i_in.write_word_7, i_in.write_word_6, i_in.write_word_5,
                       i_in.write_word_4, i_in.write_word_3, i_in.write_word_2,
                       i_in.write_word_1, i_in.write_word_0};

    always_comb begin
        is_rw      = (i_in.mode == flbm_pkg::MODE_READ) || (i_in.mode == flbm_pkg::MODE_WRITE);
        owner_free = (r_owner == flbm_pkg::NO_OWNER);
        owner_ok   = owner_free || (r_owner == i_in.requester_id);
        serve      = is_rw && owner_ok && (r_elapsed >= r_latency);
        n_elapsed  = r_elapsed;
        n_owner    = r_owner;
        if (i_in.mode == flbm_pkg::MODE_TICK) begin
            if (r_elapsed != flbm_pkg::ELAPSED_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end else if (serve) begin
            n_elapsed = '0;
            n_owner   = flbm_pkg::NO_OWNER;
        end else if (is_rw && owner_free) begin
            n_owner = i_in.requester_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latency <= flbm_pkg::LAT_RESET;
        end else if (i_cfg_we) begin
            r_latency <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= flbm_pkg::ELAPSED_RESET;
            r_owner   <= flbm_pkg::NO_OWNER;
        end else if (accept) begin
            r_elapsed <= n_elapsed;
            r_owner   <= n_owner;
        end
    end

    // block RAM, one row per block
    always_ff @(posedge i_clk) begin
        if (accept && serve && in_store) begin
            if (i_in.mode == flbm_pkg::MODE_WRITE) begin
                mem[mem_idx] <= wrow;
            end else begin
                r_rdata <= mem[mem_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (advance) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_done <= serve;
            r_pend_rd   <= serve && in_store && (i_in.mode == flbm_pkg::MODE_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_done <= r_pend_done;
            r_out_row  <= r_pend_rd ? r_rdata : '0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.done_res    = r_out_done;
    assign o_out.read_word_0 = r_out_row[0*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_1 = r_out_row[1*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_2 = r_out_row[2*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_3 = r_out_row[3*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_4 = r_out_row[4*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_5 = r_out_row[5*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_6 = r_out_row[6*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];
    assign o_out.read_word_7 = r_out_row[7*flbm_pkg::WORD_W +: flbm_pkg::WORD_W];

endmodule
